@@ src/srt_pkg.sv @@
// shared types and codes for the sorted relocation table
`default_nettype none
package srt_pkg;
    typedef enum logic [1:0] {
        OP_CLEAR = 2'd0,
        OP_ADD   = 2'd1,
        OP_FIND_OLD = 2'd2,
        OP_FIND_NEW = 2'd3
    } t_opcode;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_MISS = 2'd1,
        ST_FULL = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SRCH,
        S_SRCH_RD,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_SCAN,
        S_DONE
    } t_state;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [31:0] key_old;
        logic [31:0] value_new;
        logic [31:0] owner_id;
    } t_req;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] found_old;
        logic [31:0] found_new;
        logic [31:0] found_owner;
        logic [6:0]  entry_count;
    } t_rsp;

    typedef struct packed {
        logic [31:0] old_key;
        logic [31:0] new_val;
        logic [31:0] owner;
    } t_entry;
endpackage
`default_nettype wire

@@ src/srt_if.sv @@
// valid/ready channel carrying one item
`default_nettype none
interface srt_req_if;
    logic         valid;
    logic         ready;
    srt_pkg::t_req data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface srt_rsp_if;
    logic         valid;
    logic         ready;
    srt_pkg::t_rsp data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ src/sorted_relocation_table_unit.sv @@
// sorted relocation table: top level with sequencer and entry memory
// Usage: requests arrive on i_req (opcode, key_old, value_new, owner_id) and
// each one yields exactly one response on o_rsp (status, found fields, count).
// One item is handled at a time against an entry memory with a registered
// read port, one entry read per cycle. Per opcode:
//  clear: the fill count is set to zero;
//  find by old key: binary search over the filled entries, a search and a read
//  state per halving step, at most 6 steps at 63 entries and 7 at 64;
//  add: the search; a found key is overwritten in place, else, unless full,
//  entries from the insert position up move one place with a read and a write
//  state each, then the new entry is written at the insert position;
//  find by new value: a scan from entry 0 up to the fill count.
// A new request is taken only once the response has been taken. The response
// sits in an output register; while the receiver stalls it holds and no new
// request is taken. Reset clears the fill count and the sequencer; table
// contents are not cleared and are only used below the fill count, so no
// clearing pass is needed.
`default_nettype none
module sorted_relocation_table_unit #(
    parameter int TABLE_DEPTH = 64
) (
    input  wire i_clk,
    input  wire i_rst_n,
    srt_req_if.sink   i_req,
    srt_rsp_if.source o_rsp
);
    localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CW = $clog2(TABLE_DEPTH + 1);

    srt_pkg::t_state r_state, n_state;
    srt_pkg::t_req   r_req;
    logic [CW-1:0]   r_fill;
    logic [CW-1:0]   r_lo, r_hi, r_idx;
    logic [CW-1:0]   w_mid;
    srt_pkg::t_entry w_rd;
    logic            r_valid;
    srt_pkg::t_rsp   r_rsp;
    logic            w_we;
    logic [AW-1:0]   w_waddr, w_raddr;
    srt_pkg::t_entry w_wdata;
    logic            w_acc, w_done;
    srt_pkg::t_rsp   w_rsp;
    logic [CW-1:0]   w_fill_nxt;

    srt_mem #(.AW(AW)) u_mem (
        .i_clk(i_clk), .i_we(w_we), .i_waddr(w_waddr), .i_wdata(w_wdata),
        .i_raddr(w_raddr), .o_rdata(w_rd)
    );

    assign w_mid = r_lo + ((r_hi - r_lo) >> 1);
    assign w_acc = i_req.valid && i_req.ready;
    assign i_req.ready = (r_state == srt_pkg::S_IDLE) && !r_valid;
    assign o_rsp.valid = r_valid;
    assign o_rsp.data  = r_rsp;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            srt_pkg::S_IDLE: begin
                if (w_acc) begin
                    unique case (srt_pkg::t_opcode'(i_req.data.opcode))
                        srt_pkg::OP_CLEAR:    n_state = srt_pkg::S_DONE;
                        srt_pkg::OP_FIND_NEW: n_state = srt_pkg::S_SCAN;
                        default:              n_state = srt_pkg::S_SRCH;
                    endcase
                end
            end
            srt_pkg::S_SRCH: begin
                if (r_lo < r_hi) n_state = srt_pkg::S_SRCH_RD;
                else if (r_req.opcode == srt_pkg::OP_ADD && r_fill < CW'(TABLE_DEPTH))
                    n_state = srt_pkg::S_SHIFT_RD;
                else n_state = srt_pkg::S_IDLE;
            end
            srt_pkg::S_SRCH_RD: begin
                if (w_rd.old_key == r_req.key_old) n_state = srt_pkg::S_IDLE;
                else n_state = srt_pkg::S_SRCH;
            end
            srt_pkg::S_SHIFT_RD: begin
                n_state = (r_idx == r_lo) ? srt_pkg::S_IDLE : srt_pkg::S_SHIFT_WR;
            end
            srt_pkg::S_SHIFT_WR: n_state = srt_pkg::S_SHIFT_RD;
            srt_pkg::S_SCAN: begin
                if (r_idx != '0 && w_rd.new_val == r_req.value_new) n_state = srt_pkg::S_IDLE;
                else if (r_idx >= r_fill) n_state = srt_pkg::S_IDLE;
            end
            srt_pkg::S_DONE: n_state = srt_pkg::S_IDLE;
            default: n_state = srt_pkg::S_IDLE;
        endcase
    end

    // memory control and response building
    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_idx[AW-1:0];
        w_wdata = '{old_key: r_req.key_old, new_val: r_req.value_new,
                    owner: r_req.owner_id};
        w_raddr = w_mid[AW-1:0];
        w_done  = 1'b0;
        w_rsp   = '0;
        w_fill_nxt = r_fill;
        unique case (r_state)
            srt_pkg::S_SRCH: begin
                // range empty: the key is absent, lo is the insert position
                if (!(r_lo < r_hi)) begin
                    if (r_req.opcode != srt_pkg::OP_ADD) begin
                        w_done = 1'b1;
                        w_rsp.status = srt_pkg::ST_MISS;
                    end else if (!(r_fill < CW'(TABLE_DEPTH))) begin
                        w_done = 1'b1;
                        w_rsp.status = srt_pkg::ST_FULL;
                    end
                end
            end
            srt_pkg::S_SRCH_RD: begin
                // keys are unique, so an equal middle entry is the match
                if (w_rd.old_key == r_req.key_old) begin
                    w_done = 1'b1;
                    if (r_req.opcode == srt_pkg::OP_ADD) begin
                        w_we = 1'b1;
                        w_waddr = w_mid[AW-1:0];
                    end else begin
                        w_rsp.found_old = w_rd.old_key;
                        w_rsp.found_new = w_rd.new_val;
                        w_rsp.found_owner = w_rd.owner;
                    end
                end
            end
            srt_pkg::S_SHIFT_RD: begin
                w_raddr = r_idx[AW-1:0] - AW'(1);
                if (r_idx == r_lo) begin
                    w_we = 1'b1;
                    w_done = 1'b1;
                    w_fill_nxt = r_fill + CW'(1);
                end
            end
            srt_pkg::S_SHIFT_WR: begin
                w_we = 1'b1;
                w_wdata = w_rd;
            end
            srt_pkg::S_SCAN: begin
                // reads entry idx while comparing entry idx-1 from the registered read port
                w_raddr = r_idx[AW-1:0];
                if (r_idx != '0 && w_rd.new_val == r_req.value_new) begin
                    w_done = 1'b1;
                    w_rsp.found_old = w_rd.old_key;
                    w_rsp.found_new = w_rd.new_val;
                    w_rsp.found_owner = w_rd.owner;
                end else if (r_idx >= r_fill) begin
                    w_done = 1'b1;
                    w_rsp.status = srt_pkg::ST_MISS;
                end
            end
            srt_pkg::S_DONE: begin
                w_done = 1'b1;
                w_fill_nxt = '0;
            end
            default: ;
        endcase
        w_rsp.entry_count = 7'(w_fill_nxt);
    end

    // sequencer registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= srt_pkg::S_IDLE;
            r_fill  <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (o_rsp.valid && o_rsp.ready) r_valid <= 1'b0;
            if (w_done && r_state != srt_pkg::S_IDLE) begin
                r_valid <= 1'b1;
                r_fill  <= w_fill_nxt;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_req <= i_req.data;
            r_lo  <= '0;
            r_hi  <= r_fill;
            r_idx <= '0;
        end
        if (w_done && r_state != srt_pkg::S_IDLE) r_rsp <= w_rsp;
        unique case (r_state)
            srt_pkg::S_SRCH_RD: begin
                if (w_rd.old_key < r_req.key_old) r_lo <= w_mid + CW'(1);
                else r_hi <= w_mid;
            end
            srt_pkg::S_SRCH: r_idx <= r_fill;
            srt_pkg::S_SHIFT_WR: r_idx <= r_idx - CW'(1);
            srt_pkg::S_SCAN: r_idx <= r_idx + CW'(1);
            default: ;
        endcase
    end

    a_fill_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CW'(TABLE_DEPTH)) else $error("fill count beyond depth");
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc |=> !i_req.ready) else $error("accepted while busy");
    a_one_rsp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !o_rsp.ready) |=> r_valid && $stable(r_rsp))
        else $error("response lost");
    a_fill_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_fill != $past(r_fill)) |-> (r_fill == '0 || r_fill == $past(r_fill) + CW'(1)))
        else $error("fill count jump");
endmodule
`default_nettype wire

@@ src/srt_mem.sv @@
// entry memory, one write and one registered read port
`default_nettype none
module srt_mem #(
    parameter int AW = 6
) (
    input  wire                 i_clk,
    input  wire                 i_we,
    input  wire [AW-1:0]        i_waddr,
    input  wire srt_pkg::t_entry i_wdata,
    input  wire [AW-1:0]        i_raddr,
    output srt_pkg::t_entry     o_rdata
);
    srt_pkg::t_entry r_mem [2**AW];

    // synchronous write and read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire
